// ===== hdl/afade_pkg.sv =====
// ---------------------------------------------------------------------------
// afade_pkg
// Shared constants, codes and arithmetic helpers of the audio output FIFO
// with fade ramp.
// ---------------------------------------------------------------------------
package afade_pkg;

   localparam int DEPTH           = 4096;
   localparam int ADDR_W          = $clog2(DEPTH);
   localparam int CNT_W           = $clog2(DEPTH + 1);
   localparam int FILL_W          = 13;
   localparam int SAMPLE_W        = 16;
   localparam int GAIN_W          = 13;
   localparam int STEP_W          = 12;
   localparam int KIND_W          = 3;
   localparam int STATUS_W        = 2;
   localparam int PROD_W          = SAMPLE_W + GAIN_W;
   localparam int GAIN_SHIFT      = 12;
   localparam int FULL_GAIN       = 4096;
   localparam int FADE_STEP_RESET = 64;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 3'd0,
      KIND_PULL   = 3'd1,
      KIND_START  = 3'd2,
      KIND_STOP   = 3'd3,
      KIND_PAUSE  = 3'd4,
      KIND_RESUME = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      RUN_STOPPED = 2'd0,
      RUN_PLAYING = 2'd1,
      RUN_PAUSED  = 2'd2
   } run_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL1 = 4'b0010,
      ST_MUL2 = 4'b0100,
      ST_EMIT = 4'b1000
   } fsm_type;

   // floor(s * g / 4096) for a gain up to full scale
   function automatic logic signed [SAMPLE_W-1:0] afade_scale(
      input logic signed [SAMPLE_W-1:0] s,
      input logic [GAIN_W-1:0]          g
   );
      logic signed [PROD_W-1:0] prod;
      prod = PROD_W'(s) * $signed({{(PROD_W-GAIN_W){1'b0}}, g});
      return prod[GAIN_SHIFT+SAMPLE_W-1:GAIN_SHIFT];
   endfunction

   function automatic logic [ADDR_W-1:0] afade_wrap(input logic [ADDR_W-1:0] p);
      return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + ADDR_W'(1);
   endfunction

endpackage

// ===== hdl/afade_if.sv =====
// ---------------------------------------------------------------------------
// afade channel interfaces
// Request, response and register-write channels of the audio output FIFO.
// ---------------------------------------------------------------------------
interface afade_req_if import afade_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          kind;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic                       page_start;
   logic                       last_of_chunk;

   modport source (output valid, kind, sample_in, page_start, last_of_chunk,
                   input ready);
   modport sink   (input valid, kind, sample_in, page_start, last_of_chunk,
                   output ready);
endinterface

interface afade_rsp_if import afade_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       underrun;
   logic                       dropped;
   logic                       rejected;
   logic [FILL_W-1:0]          fill_level;
   logic [STATUS_W-1:0]        play_status;

   modport source (output valid, sample_out, underrun, dropped, rejected,
                   fill_level, play_status, input ready);
   modport sink   (input valid, sample_out, underrun, dropped, rejected,
                   fill_level, play_status, output ready);
endinterface

interface afade_csr_if import afade_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STEP_W-1:0] fade_step;

   modport source (output valid, fade_step, input ready);
   modport sink   (input valid, fade_step, output ready);
endinterface

// ===== hdl/audio_fifo_with_fade_ramp.sv =====
// ---------------------------------------------------------------------------
// audio_fifo_with_fade_ramp
// Mono sample ring buffer with soft start and soft stop fade ramp.
//
//   channel  | direction | contents
//   ---------+-----------+--------------------------------------------------
//   req_if   | in        | kind, sample_in, page_start, last_of_chunk
//   rsp_if   | out       | sample_out, underrun, dropped, rejected,
//            |           | fill_level, play_status
//   csr_if   | in        | fade_step
//
// Push, control and empty or idle pulls finish in the accept cycle; a pull
// that reads the sample RAM runs through RAM read, first scale multiply,
// second scale multiply and result load. One transaction is in work at a time.
// Synchronous reset clears pointers, count, gain and state; the RAM holds
// no reset state and only held entries are read. A stalled response holds
// its register and blocks the next request until taken.
// ---------------------------------------------------------------------------
module audio_fifo_with_fade_ramp import afade_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   afade_req_if.sink   req_if,
   afade_rsp_if.source rsp_if,
   afade_csr_if.sink   csr_if
);

   logic [ADDR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           held_ff, held_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic                       up_ff, up_in;
   logic                       down_ff, down_in;
   run_type                    run_ff, run_in;
   logic [STEP_W-1:0]          step_ff;
   fsm_type                    state_ff, state_in;

   logic [GAIN_W-1:0]          g1_ff, g1_in;
   logic [GAIN_W-1:0]          g2_ff, g2_in;
   logic                       use1_ff, use1_in;
   logic                       use2_ff, use2_in;
   logic signed [SAMPLE_W-1:0] s1_ff, s1_in;
   logic signed [SAMPLE_W-1:0] s2_ff, s2_in;
   logic [FILL_W-1:0]          pend_fill_ff, pend_fill_in;
   run_type                    pend_run_ff, pend_run_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_underrun_ff, rsp_underrun_in;
   logic                       rsp_dropped_ff, rsp_dropped_in;
   logic                       rsp_rejected_ff, rsp_rejected_in;
   logic [FILL_W-1:0]          rsp_fill_ff, rsp_fill_in;
   run_type                    rsp_run_ff, rsp_run_in;

   logic                       accept;
   logic                       out_free;
   logic                       ram_wr;
   logic                       ram_rd;
   logic [SAMPLE_W-1:0]        ram_q;

   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE) && out_free;
   assign accept        = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;

   assign ram_wr = accept && (kind_type'(req_if.kind) == KIND_PUSH) && (run_ff != RUN_PAUSED);
   assign ram_rd = accept && (kind_type'(req_if.kind) == KIND_PULL) && (run_ff == RUN_PLAYING)
                   && (held_ff != '0);

   afade_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_if.sample_in),
      .rd_en   (ram_rd),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_q)
   );

   always_comb begin
      logic [GAIN_W-1:0] g_mid;
      logic [GAIN_W-1:0] g_sum;
      logic [GAIN_W-1:0] step_w;

      wr_ptr_in       = wr_ptr_ff;
      rd_ptr_in       = rd_ptr_ff;
      held_in         = held_ff;
      gain_in         = gain_ff;
      up_in           = up_ff;
      down_in         = down_ff;
      run_in          = run_ff;
      state_in        = state_ff;
      g1_in           = g1_ff;
      g2_in           = g2_ff;
      use1_in         = use1_ff;
      use2_in         = use2_ff;
      s1_in           = s1_ff;
      s2_in           = s2_ff;
      pend_fill_in    = pend_fill_ff;
      pend_run_in     = pend_run_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_sample_in   = rsp_sample_ff;
      rsp_underrun_in = rsp_underrun_ff;
      rsp_dropped_in  = rsp_dropped_ff;
      rsp_rejected_in = rsp_rejected_ff;
      rsp_fill_in     = rsp_fill_ff;
      rsp_run_in      = rsp_run_ff;

      step_w = GAIN_W'(step_ff);
      g_mid  = gain_ff;
      g_sum  = gain_ff + step_w;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_sample_in   = '0;
               rsp_underrun_in = 1'b0;
               rsp_dropped_in  = 1'b0;
               rsp_rejected_in = 1'b0;
               unique case (kind_type'(req_if.kind))
                  KIND_PUSH: begin
                     if (run_ff == RUN_PAUSED) begin
                        rsp_rejected_in = 1'b1;
                     end else begin
                        wr_ptr_in = afade_wrap(wr_ptr_ff);
                        if (held_ff >= CNT_W'(DEPTH)) begin
                           rd_ptr_in      = afade_wrap(rd_ptr_ff);
                           held_in        = CNT_W'(DEPTH);
                           rsp_dropped_in = 1'b1;
                        end else begin
                           held_in = held_ff + CNT_W'(1);
                        end
                     end
                  end
                  KIND_PULL: begin
                     if (run_ff == RUN_PLAYING) begin
                        if (req_if.page_start && up_ff && (gain_ff < GAIN_W'(FULL_GAIN))) begin
                           if (g_sum >= GAIN_W'(FULL_GAIN)) begin
                              g_mid = GAIN_W'(FULL_GAIN);
                              up_in = 1'b0;
                           end else begin
                              g_mid = g_sum;
                           end
                        end
                        g1_in   = g_mid;
                        use1_in = (g_mid < GAIN_W'(FULL_GAIN));
                        gain_in = g_mid;
                        if (held_ff != '0) begin
                           rd_ptr_in = afade_wrap(rd_ptr_ff);
                           held_in   = held_ff - CNT_W'(1);
                        end else begin
                           rsp_underrun_in = 1'b1;
                        end
                        use2_in = down_ff;
                        if (down_ff) begin
                           if (g_mid > step_w) begin
                              gain_in = g_mid - step_w;
                           end else begin
                              gain_in   = '0;
                              down_in   = 1'b0;
                              up_in     = 1'b0;
                              run_in    = RUN_STOPPED;
                              wr_ptr_in = '0;
                              rd_ptr_in = '0;
                              held_in   = '0;
                           end
                        end
                        g2_in = gain_in;
                     end
                  end
                  KIND_START: begin
                     if (run_ff != RUN_PLAYING) begin
                        if (held_ff == '0) begin
                           wr_ptr_in = '0;
                           rd_ptr_in = '0;
                        end
                        gain_in = '0;
                        up_in   = 1'b1;
                        down_in = 1'b0;
                        run_in  = RUN_PLAYING;
                     end
                  end
                  KIND_STOP: begin
                     if (run_ff != RUN_STOPPED) begin
                        down_in = 1'b1;
                     end
                  end
                  KIND_PAUSE: begin
                     if (run_ff == RUN_PLAYING) begin
                        run_in = RUN_PAUSED;
                     end
                  end
                  KIND_RESUME: begin
                     if (run_ff == RUN_PAUSED) begin
                        run_in = RUN_PLAYING;
                     end
                  end
                  default: begin
                  end
               endcase
               if (ram_rd) begin
                  pend_fill_in = FILL_W'(held_in);
                  pend_run_in  = run_in;
                  state_in     = ST_MUL1;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_fill_in  = FILL_W'(held_in);
                  rsp_run_in   = run_in;
               end
            end
         end
         ST_MUL1: begin
            s1_in    = use1_ff ? afade_scale($signed(ram_q), g1_ff) : $signed(ram_q);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            s2_in    = use2_ff ? afade_scale(s1_ff, g2_ff) : s1_ff;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_sample_in   = s2_ff;
               rsp_underrun_in = 1'b0;
               rsp_dropped_in  = 1'b0;
               rsp_rejected_in = 1'b0;
               rsp_fill_in     = pend_fill_ff;
               rsp_run_in      = pend_run_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         held_ff      <= '0;
         gain_ff      <= '0;
         up_ff        <= 1'b0;
         down_ff      <= 1'b0;
         run_ff       <= RUN_STOPPED;
         step_ff      <= STEP_W'(FADE_STEP_RESET);
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         held_ff      <= held_in;
         gain_ff      <= gain_in;
         up_ff        <= up_in;
         down_ff      <= down_in;
         run_ff       <= run_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            step_ff <= csr_if.fade_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      g1_ff           <= g1_in;
      g2_ff           <= g2_in;
      use1_ff         <= use1_in;
      use2_ff         <= use2_in;
      s1_ff           <= s1_in;
      s2_ff           <= s2_in;
      pend_fill_ff    <= pend_fill_in;
      pend_run_ff     <= pend_run_in;
      rsp_sample_ff   <= rsp_sample_in;
      rsp_underrun_ff <= rsp_underrun_in;
      rsp_dropped_ff  <= rsp_dropped_in;
      rsp_rejected_ff <= rsp_rejected_in;
      rsp_fill_ff     <= rsp_fill_in;
      rsp_run_ff      <= rsp_run_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.sample_out  = rsp_sample_ff;
   assign rsp_if.underrun    = rsp_underrun_ff;
   assign rsp_if.dropped     = rsp_dropped_ff;
   assign rsp_if.rejected    = rsp_rejected_ff;
   assign rsp_if.fill_level  = rsp_fill_ff;
   assign rsp_if.play_status = rsp_run_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(DEPTH))
      else $error("held count above depth");

   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= GAIN_W'(FULL_GAIN))
      else $error("fade gain above full scale");

   a_stop_no_fade: assert property (@(posedge clock) disable iff (reset)
      (run_ff == RUN_STOPPED) |-> !down_ff)
      else $error("fade-out armed while stopped");

   a_read_path: assert property (@(posedge clock) disable iff (reset)
      ram_rd |=> (state_ff == ST_MUL1))
      else $error("RAM read without scale pass");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (held_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("pointers differ while empty");

endmodule

// ===== hdl/afade_ram.sv =====
// ---------------------------------------------------------------------------
// afade_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module afade_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: audio FIFO with fade ramp
// Self-checking bench for the mono sample ring buffer. A directed table
// covers reset state, field extremes, every command and the corner cases of
// pausing, start/stop and fade end. A push burst runs while the response
// side is held off. Random phases under several fade steps follow. Every
// response is checked against a pinned table value or an in-bench predictor
// of the ring, gain ramp and play state.
// ---------------------------------------------------------------------------
module tb_top;
   import afade_pkg::*;

   typedef struct packed {
      logic [15:0] sample_out;
      logic        underrun;
      logic        dropped;
      logic        rejected;
      logic [12:0] fill_level;
      logic [1:0]  play_status;
   } pcm_result_type;

   typedef struct {
      bit             is_cfg;
      logic [2:0]     kind;
      logic [15:0]    value;
      bit             page;
      bit             last;
      bit             pinned;
      pcm_result_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   afade_req_if req_ch ();
   afade_rsp_if rsp_ch ();
   afade_csr_if csr_ch ();

   audio_fifo_with_fade_ramp uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // predictor state
   logic signed [15:0] pcm_ring [DEPTH];
   int      wr_idx, rd_idx, held_n, gain_now, step_now;
   bit      up_now, down_now;
   run_type run_now;

   pcm_result_type pcm_result_q[$];
   stim_row_type   stim_rows[$];

   pcm_result_type pin_exp;
   bit             pin_on;
   int             burst_left;
   bit             long_hold_request;
   int             fail_count;
   int             items_seen, results_seen, drops_seen, underruns_seen, rejects_seen;

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("Timeout: %0d transactions still expected", pcm_result_q.size());
      $display("Test completed with failures");
      $finish;
   end

   function automatic int ring_next(int p);
      return (p >= DEPTH - 1) ? 0 : p + 1;
   endfunction

   // floor(s * g / 4096)
   function automatic int gain_scale(int s, int g);
      int p;
      p = s * g;
      return p >>> GAIN_SHIFT;
   endfunction

   function automatic pcm_result_type compute_pcm_result(logic [2:0] kind, logic [15:0] sample,
                                                         logic page);
      pcm_result_type r;
      int s;
      r = '0;
      s = 0;
      case (kind)
         KIND_PUSH: begin
            if (run_now == RUN_PAUSED) begin
               r.rejected = 1'b1;
            end else begin
               pcm_ring[wr_idx] = sample;
               wr_idx = ring_next(wr_idx);
               if (held_n >= DEPTH) begin
                  rd_idx = ring_next(rd_idx);
                  held_n = DEPTH;
                  r.dropped = 1'b1;
               end else begin
                  held_n++;
               end
            end
         end
         KIND_PULL: begin
            if (run_now == RUN_PLAYING) begin
               if (page && up_now && gain_now < FULL_GAIN) begin
                  gain_now += step_now;
                  if (gain_now >= FULL_GAIN) begin
                     gain_now = FULL_GAIN;
                     up_now = 1'b0;
                  end
               end
               if (held_n > 0) begin
                  s = pcm_ring[rd_idx];
                  rd_idx = ring_next(rd_idx);
                  held_n--;
               end else begin
                  r.underrun = 1'b1;
               end
               if (gain_now < FULL_GAIN) s = gain_scale(s, gain_now);
               if (down_now) begin
                  if (gain_now > step_now) begin
                     gain_now -= step_now;
                  end else begin
                     gain_now = 0;
                     down_now = 1'b0;
                     up_now = 1'b0;
                     run_now = RUN_STOPPED;
                     wr_idx = 0;
                     rd_idx = 0;
                     held_n = 0;
                  end
                  s = gain_scale(s, gain_now);
               end
               r.sample_out = s[15:0];
            end
         end
         KIND_START: begin
            if (run_now != RUN_PLAYING) begin
               if (held_n == 0) begin
                  wr_idx = 0;
                  rd_idx = 0;
               end
               gain_now = 0;
               up_now = 1'b1;
               down_now = 1'b0;
               run_now = RUN_PLAYING;
            end
         end
         KIND_STOP: begin
            if (run_now != RUN_STOPPED) down_now = 1'b1;
         end
         KIND_PAUSE: begin
            if (run_now == RUN_PLAYING) run_now = RUN_PAUSED;
         end
         KIND_RESUME: begin
            if (run_now == RUN_PAUSED) run_now = RUN_PLAYING;
         end
         default: ;
      endcase
      r.fill_level = held_n[12:0];
      r.play_status = run_now;
      return r;
   endfunction

   always @(posedge clock) begin
      pcm_result_type pred;
      pcm_result_type want;
      if (reset) begin
         rd_idx = 0;
         wr_idx = 0;
         held_n = 0;
         gain_now = 0;
         up_now = 1'b0;
         down_now = 1'b0;
         run_now = RUN_STOPPED;
         step_now = FADE_STEP_RESET;
      end else begin
         if (csr_ch.valid && csr_ch.ready) step_now = csr_ch.fade_step;
         if (req_ch.valid && req_ch.ready) begin
            pred = compute_pcm_result(req_ch.kind, req_ch.sample_in, req_ch.page_start);
            pcm_result_q.push_back(pin_on ? pin_exp : pred);
            items_seen++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (rsp_ch.dropped === 1'b1) drops_seen++;
            if (rsp_ch.underrun === 1'b1) underruns_seen++;
            if (rsp_ch.rejected === 1'b1) rejects_seen++;
            if (pcm_result_q.size() == 0) begin
               $error("unexpected response transaction");
               fail_count++;
            end else begin
               want = pcm_result_q.pop_front();
               if (want.sample_out !== rsp_ch.sample_out) begin
                  $error("sample_out: expected %0d, got %0d",
                         $signed(want.sample_out), rsp_ch.sample_out);
                  fail_count++;
               end
               if (want.underrun !== rsp_ch.underrun) begin
                  $error("underrun: expected %0b, got %0b", want.underrun, rsp_ch.underrun);
                  fail_count++;
               end
               if (want.dropped !== rsp_ch.dropped) begin
                  $error("dropped: expected %0b, got %0b", want.dropped, rsp_ch.dropped);
                  fail_count++;
               end
               if (want.rejected !== rsp_ch.rejected) begin
                  $error("rejected: expected %0b, got %0b", want.rejected, rsp_ch.rejected);
                  fail_count++;
               end
               if (want.fill_level !== rsp_ch.fill_level) begin
                  $error("fill_level: expected %0d, got %0d",
                         want.fill_level, rsp_ch.fill_level);
                  fail_count++;
               end
               if (want.play_status !== rsp_ch.play_status) begin
                  $error("play_status: expected %0d, got %0d",
                         want.play_status, rsp_ch.play_status);
                  fail_count++;
               end
            end
         end
      end
   end

   // response side: stall pattern plus one long hold-off
   initial begin
      int mode;
      int left;
      int hold_left;
      bit hold_done;
      logic [15:0] pat;
      rsp_ch.ready = 1'b0;
      mode = 0;
      left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      pat = '1;
      forever begin
         @(posedge clock);
         if (long_hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 500;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(16, 96);
            pat = $urandom;
         end
         left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
               2: begin
                  rsp_ch.ready <= pat[0];
                  pat = {pat[0], pat[15:1]};
               end
               default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic send_req(input logic [2:0] k, input logic [15:0] v, input logic pg,
                           input logic lc, input bit pinned, input pcm_result_type want);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_ch.valid         <= 1'b1;
      req_ch.kind          <= k;
      req_ch.sample_in     <= v;
      req_ch.page_start    <= pg;
      req_ch.last_of_chunk <= lc;
      pin_on               <= pinned;
      pin_exp              <= want;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // wait for the block to drain, then write the fade step
   task automatic write_fade_step(input logic [11:0] step);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pcm_result_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_ch.valid     <= 1'b1;
      csr_ch.fade_step <= step;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      burst_left = 0;
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 11))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void row_item(logic [2:0] k, logic [15:0] v, bit pg, bit lc);
      stim_row_type r;
      r.is_cfg = 1'b0;
      r.kind = k;
      r.value = v;
      r.page = pg;
      r.last = lc;
      r.pinned = 1'b0;
      r.want = '0;
      stim_rows.push_back(r);
   endfunction

   function automatic void row_pin(logic [2:0] k, logic [15:0] v, bit pg, bit lc,
                                   logic [15:0] so, bit ur, bit dr, bit rj, int fill,
                                   run_type st);
      stim_row_type r;
      r.is_cfg = 1'b0;
      r.kind = k;
      r.value = v;
      r.page = pg;
      r.last = lc;
      r.pinned = 1'b1;
      r.want = '{so, ur, dr, rj, fill[12:0], st};
      stim_rows.push_back(r);
   endfunction

   function automatic void row_cfg(logic [11:0] step);
      stim_row_type r;
      r.is_cfg = 1'b1;
      r.kind = KIND_PUSH;
      r.value = {4'h0, step};
      r.page = 1'b0;
      r.last = 1'b0;
      r.pinned = 1'b0;
      r.want = '0;
      stim_rows.push_back(r);
   endfunction

   initial begin
      int p;
      int n;
      int r;
      logic [2:0] k;
      logic [11:0] step_v;
      pcm_result_type none;
      none = '0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_PUSH;
      req_ch.sample_in = '0;
      req_ch.page_start = 1'b0;
      req_ch.last_of_chunk = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.fade_step = '0;
      pin_on = 1'b0;
      pin_exp = none;
      burst_left = 0;
      long_hold_request = 1'b0;
      fail_count = 0;
      items_seen = 0;
      results_seen = 0;
      drops_seen = 0;
      underruns_seen = 0;
      rejects_seen = 0;

      // idle commands from reset, preload at extremes, start, pause/stop/resume
      row_pin(KIND_PULL,   16'h0000, 1, 0, 16'h0000, 0, 0, 0, 0, RUN_STOPPED);
      row_pin(KIND_STOP,   16'h0000, 0, 0, 16'h0000, 0, 0, 0, 0, RUN_STOPPED);
      row_pin(KIND_PAUSE,  16'h0000, 0, 0, 16'h0000, 0, 0, 0, 0, RUN_STOPPED);
      row_pin(KIND_RESUME, 16'h0000, 0, 0, 16'h0000, 0, 0, 0, 0, RUN_STOPPED);
      row_pin(KIND_PUSH,   16'h7FFF, 0, 1, 16'h0000, 0, 0, 0, 1, RUN_STOPPED);
      row_pin(KIND_PUSH,   16'h8000, 1, 0, 16'h0000, 0, 0, 0, 2, RUN_STOPPED);
      row_pin(3'd7,        16'hFFFF, 1, 1, 16'h0000, 0, 0, 0, 2, RUN_STOPPED);
      row_pin(KIND_START,  16'h0000, 0, 0, 16'h0000, 0, 0, 0, 2, RUN_PLAYING);
      row_pin(KIND_START,  16'h0000, 0, 0, 16'h0000, 0, 0, 0, 2, RUN_PLAYING);
      row_item(KIND_PULL,  16'h0000, 1, 0);
      row_pin(KIND_PAUSE,  16'h0000, 0, 0, 16'h0000, 0, 0, 0, 1, RUN_PAUSED);
      row_pin(KIND_PUSH,   16'h1234, 0, 0, 16'h0000, 0, 0, 1, 1, RUN_PAUSED);
      row_pin(KIND_STOP,   16'h0000, 0, 0, 16'h0000, 0, 0, 0, 1, RUN_PAUSED);
      row_pin(KIND_RESUME, 16'h0000, 0, 0, 16'h0000, 0, 0, 0, 1, RUN_PLAYING);
      row_pin(KIND_PULL,   16'h0000, 0, 0, 16'h0000, 0, 0, 0, 0, RUN_STOPPED);
      // largest step: ramp to full gain, fade out in two pulls
      row_cfg(12'hFFF);
      row_pin(KIND_START,  16'h0000, 0, 0, 16'h0000, 0, 0, 0, 0, RUN_PLAYING);
      row_pin(KIND_PULL,   16'h0000, 1, 0, 16'h0000, 1, 0, 0, 0, RUN_PLAYING);
      row_pin(KIND_PUSH,   16'd12345, 0, 1, 16'h0000, 0, 0, 0, 1, RUN_PLAYING);
      row_pin(KIND_PULL,   16'h0000, 1, 0, 16'd12345, 0, 0, 0, 0, RUN_PLAYING);
      row_item(KIND_PUSH,  16'hFFF9, 0, 0);
      row_item(KIND_STOP,  16'h0000, 0, 0);
      row_item(KIND_PULL,  16'h0000, 0, 0);
      row_pin(KIND_PULL,   16'h0000, 0, 0, 16'h0000, 1, 0, 0, 0, RUN_STOPPED);
      // zero step: ramp stalls, fade-out ends at once
      row_cfg(12'h000);
      row_pin(KIND_START,  16'h0000, 0, 0, 16'h0000, 0, 0, 0, 0, RUN_PLAYING);
      row_item(KIND_PULL,  16'h0000, 1, 0);
      row_item(KIND_STOP,  16'h0000, 0, 0);
      row_pin(KIND_PULL,   16'h0000, 1, 0, 16'h0000, 1, 0, 0, 0, RUN_STOPPED);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_cfg) begin
            write_fade_step(stim_rows[i].value[11:0]);
         end else begin
            send_req(stim_rows[i].kind, stim_rows[i].value, stim_rows[i].page,
                     stim_rows[i].last, stim_rows[i].pinned, stim_rows[i].want);
         end
      end

      // keep pushing while the response side holds off
      long_hold_request = 1'b1;
      for (n = 0; n < 240; n++) begin
         send_req(KIND_PUSH, pick_sample(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0, none);
      end

      for (p = 0; p < 6; p++) begin
         case (p)
            0: step_v = 12'd64;
            1: step_v = 12'hFFF;
            2: step_v = 12'd1;
            5: step_v = 12'd2048;
            default: step_v = 12'($urandom_range(2, 4094));
         endcase
         write_fade_step(step_v);
         for (n = 0; n < 255; n++) begin
            r = $urandom_range(0, 99);
            if (r < 38) k = KIND_PUSH;
            else if (r < 78) k = KIND_PULL;
            else if (r < 84) k = KIND_START;
            else if (r < 89) k = KIND_STOP;
            else if (r < 93) k = KIND_PAUSE;
            else if (r < 97) k = KIND_RESUME;
            else k = 3'($urandom_range(6, 7));
            send_req(k, pick_sample(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'b0, none);
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pcm_result_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d transactions and %0d responses: directed table, push burst,",
               items_seen, results_seen);
      $display("six random phases; %0d drops, %0d underruns, %0d rejected pushes seen",
               drops_seen, underruns_seen, rejects_seen);
      if (fail_count == 0 && pcm_result_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
